// ===== sv/lar_pkg.sv =====
// Shared constants, state encoding and unit handshake structs for the antialiased line rasterizer.
// Used by lar_div, lar_shade and antialiased_line_raster_core; depends on nothing.
`default_nettype none
package lar_pkg;

	localparam int COORD_BITS = 5;
	localparam int FRAC_BITS  = 16;
	localparam int DIVIDEND_W = COORD_BITS + FRAC_BITS;
	localparam int QUO_W      = FRAC_BITS + 1;
	localparam int ACC_W      = COORD_BITS + 1 + FRAC_BITS;
	localparam int PIX_W      = COORD_BITS + 1;
	localparam int COV_W      = 8;
	localparam int SHADE_W    = 8;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;
	localparam logic [SHADE_W-1:0] COLOR_RESET = 8'd255;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_MUL  = 5'b00100,
		S_WAIT = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	typedef struct packed {
		logic                    start;
		logic [DIVIDEND_W-1:0]   dividend;
		logic [COORD_BITS-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic [DIVIDEND_W-1:0]   quotient;
	} div_rsp_t;

	typedef struct packed {
		logic             valid;
		logic [COV_W-1:0] cov;
	} shd_req_t;

	typedef struct packed {
		logic               valid;
		logic [SHADE_W-1:0] shade;
	} shd_rsp_t;

endpackage
`default_nettype wire

// ===== sv/lar_div.sv =====
// Serial restoring divider for the 5.16 slope quotient: one quotient bit per cycle.
// Depends on lar_pkg.
`default_nettype none
module lar_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lar_pkg::div_req_t req,
	output lar_pkg::div_rsp_t      rsp
);

	logic [lar_pkg::DIVIDEND_W-1:0] num_q;
	logic [lar_pkg::DIVIDEND_W-1:0] quo_q;
	logic [lar_pkg::COORD_BITS-1:0] den_q;
	logic [lar_pkg::COORD_BITS-1:0] rem_q;
	logic [lar_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [lar_pkg::COORD_BITS:0]   trial;
	logic                           fits;
	logic [lar_pkg::COORD_BITS:0]   diff;

	assign trial = {rem_q, num_q[lar_pkg::DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= lar_pkg::DIV_CNT_W'(lar_pkg::DIVIDEND_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the low bits hold it
			rem_q <= fits ? diff[lar_pkg::COORD_BITS-1:0] : trial[lar_pkg::COORD_BITS-1:0];
			quo_q <= {quo_q[lar_pkg::DIVIDEND_W-2:0], fits};
			num_q <= {num_q[lar_pkg::DIVIDEND_W-2:0], 1'b0};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

// ===== sv/lar_shade.sv =====
// Coverage-to-shade unit: registered signed multiply, then blend toward background 127.
// Depends on lar_pkg.
`default_nettype none
module lar_shade (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [lar_pkg::SHADE_W-1:0]   line_color,
	input  wire lar_pkg::shd_req_t             req,
	output lar_pkg::shd_rsp_t                  rsp
);

	logic signed [8:0]  diff;
	logic signed [17:0] prod;
	logic signed [17:0] p_s1;
	logic               valid_s1;
	logic signed [17:0] sum;
	logic [9:0]         blend_hi;
	logic [9:0]         shade_w;

	assign diff = $signed(9'd127) - $signed({1'b0, line_color});
	assign prod = 18'(diff * $signed({1'b0, req.cov}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			p_s1 <= prod;
		end
	end

	// add floor(p/256) and the rounding half, then take floor of that /256
	assign sum      = p_s1 + (p_s1 >>> 8) + 18'sd128;
	assign blend_hi = sum[17:8];
	assign shade_w  = 10'd255 - {2'b00, line_color} - blend_hi;

	assign rsp.valid = valid_s1;
	assign rsp.shade = shade_w[lar_pkg::SHADE_W-1:0];

endmodule
`default_nettype wire

// ===== sv/antialiased_line_raster_core.sv =====
// Antialiased (Wu-style, 6.16) line rasterizer top: setup, sequencer and output register.
// Depends on lar_pkg, lar_div and lar_shade.
//
//  channel   | dir | payload                                               | marks
//  s_axis    | in  | tdata: start_x[4:0] start_y[9:5] end_x[14:10] end_y[19:15] | -
//  m_axis    | out | tdata: pixel_x[5:0] pixel_y[11:6] shade[19:12]         | tlast = last_pixel
//  cfg_wr    | in  | cfg_wr_data = line_color, written when cfg_wr_en      | -
//
// An axis-aligned or zero-length line is accepted and emits nothing.
// Any other line goes first through the serial slope divider, then through multiply,
// blend and present for each pixel, where present can stall on the output, 2 pixels per
// major step, with n+1 major steps for major extent n.
// s_axis_tready is high only in idle; reset returns to idle and sets line_color to 255.
`default_nettype none
module antialiased_line_raster_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// start_x[4:0], start_y[9:5], end_x[14:10], end_y[19:15], zero fill
	input  wire logic [lar_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// pixel_x[5:0], pixel_y[11:6], shade[19:12], zero fill
	output logic [lar_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	output logic                                  m_axis_tlast,
	input  wire logic                             cfg_wr_en,
	input  wire logic [lar_pkg::SHADE_W-1:0]      cfg_wr_data
);

	localparam int CB = lar_pkg::COORD_BITS;
	localparam int FB = lar_pkg::FRAC_BITS;

	lar_pkg::state_t state_q;

	logic [lar_pkg::SHADE_W-1:0] color_q;
	logic                        x_major_q;
	logic                        neg_q;
	logic                        side_q;
	logic [CB-1:0]               maj_q;
	logic [CB-1:0]               steps_q;
	logic [lar_pkg::ACC_W-1:0]   acc_q;
	logic [lar_pkg::ACC_W-1:0]   inc_q;
	logic [lar_pkg::PIX_W-1:0]   out_x_q;
	logic [lar_pkg::PIX_W-1:0]   out_y_q;
	logic [lar_pkg::SHADE_W-1:0] out_shade_q;
	logic                        out_last_q;

	lar_pkg::div_req_t div_req;
	lar_pkg::div_rsp_t div_rsp;
	lar_pkg::shd_req_t shd_req;
	lar_pkg::shd_rsp_t shd_rsp;

	// setup from the incoming transaction
	logic [CB-1:0] x1, y1, x2, y2;
	logic [CB-1:0] adx, ady;
	logic          x_major, swap, degen, in_acc, out_acc;
	logic [CB-1:0] maj0, min0, min1, dmaj, dmin_abs;

	assign x1 = s_axis_tdata[CB-1:0];
	assign y1 = s_axis_tdata[2*CB-1:CB];
	assign x2 = s_axis_tdata[3*CB-1:2*CB];
	assign y2 = s_axis_tdata[4*CB-1:3*CB];

	assign adx     = (x2 >= x1) ? x2 - x1 : x1 - x2;
	assign ady     = (y2 >= y1) ? y2 - y1 : y1 - y2;
	assign x_major = adx > ady;
	assign degen   = (x1 == x2) || (y1 == y2);
	assign swap    = x_major ? (x2 < x1) : (y2 < y1);

	always_comb begin
		if (x_major) begin
			maj0     = swap ? x2 : x1;
			min0     = swap ? y2 : y1;
			min1     = swap ? y1 : y2;
			dmaj     = adx;
			dmin_abs = ady;
		end else begin
			maj0     = swap ? y2 : y1;
			min0     = swap ? x2 : x1;
			min1     = swap ? x1 : x2;
			dmaj     = ady;
			dmin_abs = adx;
		end
	end

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	assign div_req.start    = in_acc && !degen;
	assign div_req.dividend = {dmin_abs, {FB{1'b0}}};
	assign div_req.divisor  = dmaj;

	lar_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// current pixel from the minor accumulator
	logic [lar_pkg::PIX_W-1:0] mn, minor_px, major_px;
	logic [lar_pkg::COV_W-1:0] frac;

	assign mn       = acc_q[lar_pkg::ACC_W-1:FB];
	assign frac     = acc_q[FB-1:FB-lar_pkg::COV_W];
	assign minor_px = side_q ? mn + 1'b1 : mn;
	assign major_px = {1'b0, maj_q};

	assign shd_req.valid = (state_q == lar_pkg::S_MUL);
	assign shd_req.cov   = side_q ? ~frac : frac;

	lar_shade u_shade (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_color (color_q),
		.req        (shd_req),
		.rsp        (shd_rsp)
	);

	logic [lar_pkg::ACC_W-1:0] mag;
	assign mag = lar_pkg::ACC_W'(div_rsp.quotient[lar_pkg::QUO_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lar_pkg::S_IDLE;
			color_q <= lar_pkg::COLOR_RESET;
		end else begin
			if (cfg_wr_en) begin
				color_q <= cfg_wr_data;
			end
			unique case (state_q)
				lar_pkg::S_IDLE: begin
					if (in_acc && !degen) begin
						state_q <= lar_pkg::S_DIV;
					end
				end
				lar_pkg::S_DIV: begin
					if (div_rsp.done) begin
						state_q <= lar_pkg::S_MUL;
					end
				end
				lar_pkg::S_MUL: begin
					state_q <= lar_pkg::S_WAIT;
				end
				lar_pkg::S_WAIT: begin
					state_q <= lar_pkg::S_EMIT;
				end
				lar_pkg::S_EMIT: begin
					if (out_acc) begin
						state_q <= out_last_q ? lar_pkg::S_IDLE : lar_pkg::S_MUL;
					end
				end
				default: begin
					state_q <= lar_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_major_q <= x_major;
			neg_q     <= min1 < min0;
			maj_q     <= maj0;
			steps_q   <= dmaj;
			side_q    <= 1'b0;
			acc_q     <= {1'b0, min0, {FB{1'b0}}};
		end
		if (div_rsp.done) begin
			inc_q <= neg_q ? ~mag + 1'b1 : mag;
		end
		if (state_q == lar_pkg::S_WAIT) begin
			out_x_q     <= x_major_q ? major_px : minor_px;
			out_y_q     <= x_major_q ? minor_px : major_px;
			out_shade_q <= shd_rsp.shade;
			out_last_q  <= side_q && (steps_q == '0);
		end
		// advance to the neighbour, then to the next major step
		if (state_q == lar_pkg::S_EMIT && out_acc) begin
			if (!side_q) begin
				side_q <= 1'b1;
			end else begin
				side_q  <= 1'b0;
				steps_q <= steps_q - 1'b1;
				maj_q   <= maj_q + 1'b1;
				acc_q   <= acc_q + inc_q;
			end
		end
	end

	assign s_axis_tready = (state_q == lar_pkg::S_IDLE);
	assign m_axis_tvalid = (state_q == lar_pkg::S_EMIT);
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {
		(lar_pkg::OUT_DATA_W - lar_pkg::SHADE_W - 2*lar_pkg::PIX_W)'(0),
		out_shade_q, out_y_q, out_x_q
	};

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == lar_pkg::S_DIV)
		else $error("divider finished outside the division phase");

	a_shade_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		shd_rsp.valid == (state_q == lar_pkg::S_WAIT))
		else $error("shade result out of step with the sequencer");

	a_degen_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && degen |=> state_q == lar_pkg::S_IDLE)
		else $error("axis-aligned line left idle");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && m_axis_tlast |=> state_q == lar_pkg::S_IDLE)
		else $error("last pixel did not end the line");

	a_last_on_neighbour: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> side_q)
		else $error("last flag on a main pixel");

endmodule
`default_nettype wire
